// ----- design/tctb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tctb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam logic [3:0] DECADE_LAST = 4'd9;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [1:0] UNIT_MS  = 2'd0;
    localparam logic [1:0] UNIT_CS  = 2'd1;
    localparam logic [1:0] UNIT_DS  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [2:0]  timer_index;
        logic [15:0] reload_count;
        logic        recurring;
        logic [1:0]  timer_unit;
    } item_t;

    typedef struct packed {
        logic [7:0]  fired_mask;
        logic [2:0]  units_ticked;
        logic [15:0] ms_total;
        logic [15:0] cs_total;
        logic [15:0] ds_total;
        logic [15:0] s_total;
    } result_t;

    typedef struct packed {
        logic [15:0] rld;
        logic [15:0] rem;
        logic        rpt;
        logic [1:0]  usel;
    } timer_t;

    typedef struct packed {
        logic [15:0] ms;
        logic [15:0] cs;
        logic [15:0] ds;
        logic [15:0] s;
    } totals_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- design/tctb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tctb_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire tctb_pkg::timer_t shift_in,
    input  wire logic            wr_en,
    input  wire tctb_pkg::timer_t wr_data,
    output tctb_pkg::timer_t     q
);
    import tctb_pkg::*;

    timer_t slot_reg;
    timer_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (wr_en)
        begin
            slot_next = wr_data;
        end
        else if (shift_en)
        begin
            slot_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

`default_nettype wire

// ----- design/tctb_decr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tctb_decr (
    input  wire tctb_pkg::timer_t cur,
    input  wire logic [2:0]      units,
    output tctb_pkg::timer_t     nxt,
    output logic                 fired
);
    import tctb_pkg::*;

    logic        unit_hit;
    logic        hit;
    logic [15:0] dec;

    always_comb
    begin
        case (cur.usel)
            UNIT_MS: unit_hit = units[0];
            UNIT_CS: unit_hit = units[1];
            UNIT_DS: unit_hit = units[2];
            default: unit_hit = 1'b0;
        endcase
        hit   = unit_hit && (cur.rld != 16'd0) && (cur.rem != 16'd0);
        dec   = cur.rem - 16'd1;
        fired = hit && (dec == 16'd0);
        nxt   = cur;
        if (fired && cur.rpt)
        begin
            nxt.rem = cur.rld;
        end
        else if (hit)
        begin
            nxt.rem = dec;
        end
    end

endmodule

`default_nettype wire

// ----- design/tctb_prescale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tctb_prescale (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    output logic [2:0]           units,
    output tctb_pkg::totals_t    totals
);
    import tctb_pkg::*;

    logic [3:0] ms_digit_reg, ms_digit_next;
    logic [3:0] cs_digit_reg, cs_digit_next;
    logic [3:0] ds_digit_reg, ds_digit_next;
    totals_t    cnt_reg, cnt_next;

    logic ms_wrap;
    logic cs_wrap;
    logic ds_wrap;

    assign ms_wrap = (ms_digit_reg == DECADE_LAST);
    assign cs_wrap = (cs_digit_reg == DECADE_LAST);
    assign ds_wrap = (ds_digit_reg == DECADE_LAST);
    assign units   = {ms_wrap && cs_wrap, ms_wrap, 1'b1};

    always_comb
    begin
        ms_digit_next = ms_digit_reg;
        cs_digit_next = cs_digit_reg;
        ds_digit_next = ds_digit_reg;
        cnt_next      = cnt_reg;
        if (step)
        begin
            cnt_next.ms   = cnt_reg.ms + 16'd1;
            ms_digit_next = ms_wrap ? 4'd0 : ms_digit_reg + 4'd1;
            if (ms_wrap)
            begin
                cnt_next.cs   = cnt_reg.cs + 16'd1;
                cs_digit_next = cs_wrap ? 4'd0 : cs_digit_reg + 4'd1;
                if (cs_wrap)
                begin
                    cnt_next.ds   = cnt_reg.ds + 16'd1;
                    ds_digit_next = ds_wrap ? 4'd0 : ds_digit_reg + 4'd1;
                    if (ds_wrap)
                    begin
                        cnt_next.s = cnt_reg.s + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_digit_reg <= 4'd0;
            cs_digit_reg <= 4'd0;
            ds_digit_reg <= 4'd0;
            cnt_reg      <= '0;
        end
        else
        begin
            ms_digit_reg <= ms_digit_next;
            cs_digit_reg <= cs_digit_next;
            ds_digit_reg <= ds_digit_next;
            cnt_reg      <= cnt_next;
        end
    end

    assign totals = cnt_reg;

endmodule

`default_nettype wire

// ----- design/cascaded_tick_timer_bank_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item_t (tick or set command)
// result    out        result_valid / result_stall result_t (fired bits and totals)
//
// A set command is written at its transfer; ST_EMIT then loads its result.
// A tick rotates the timer ring through the shared decrementer, one timer per cycle,
// and after ST_WALK its result is loaded from ST_EMIT into the output register.
// Reset clears all timers, digits and counts; no clearing pass is needed.
// A new item is taken while the previous result waits in the output register;
// the result stage holds until the output register is free.

module cascaded_tick_timer_bank_unit #(
    parameter int NUM_TIMERS = tctb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire tctb_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output tctb_pkg::result_t     result
);
    import tctb_pkg::*;

    localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NUM_TIMERS-1:0] mask_reg, mask_next;
    logic [2:0]            units_reg, units_next;
    logic                  tick_reg, tick_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;

    logic       accept;
    logic       walk;
    logic       out_free;
    logic       emit_load;
    logic [2:0] pre_units;
    totals_t    totals;
    timer_t     head_nxt;
    logic       head_fired;
    timer_t     wr_data;
    logic [7:0] fired8;

    timer_t cell_q [NUM_TIMERS];

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item.op == OP_TICK) ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK:
            begin
                if (cnt_reg == CNT_W'(NUM_TIMERS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        walk       = (state_reg == ST_WALK);
        emit_load  = (state_reg == ST_EMIT) && out_free;
    end

    assign accept = item_valid && !item_stall;

    tctb_prescale u_prescale (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept && (item.op == OP_TICK)),
        .units  (pre_units),
        .totals (totals)
    );

    tctb_decr u_decr (
        .cur   (cell_q[0]),
        .units (units_reg),
        .nxt   (head_nxt),
        .fired (head_fired)
    );

    assign wr_data = '{rld: item.reload_count, rem: item.reload_count,
                       rpt: item.recurring, usel: item.timer_unit};

    genvar j;
    generate
        for (j = 0; j < NUM_TIMERS; j++)
        begin : g_cell
            timer_t sin;
            logic   wen;
            if (j == NUM_TIMERS - 1)
            begin : g_tail
                assign sin = head_nxt;
            end
            else
            begin : g_mid
                assign sin = cell_q[j+1];
            end
            assign wen = accept && (item.op == OP_SET) &&
                         ({4'd0, item.timer_index} == 7'(j));
            tctb_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (walk),
                .shift_in (sin),
                .wr_en    (wen),
                .wr_data  (wr_data),
                .q        (cell_q[j])
            );
        end
    endgenerate

    generate
        for (j = 0; j < 8; j++)
        begin : g_fired
            if (j < NUM_TIMERS)
            begin : g_bit
                assign fired8[j] = mask_reg[j];
            end
            else
            begin : g_zero
                assign fired8[j] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        units_next     = units_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            cnt_next   = '0;
            mask_next  = '0;
            units_next = pre_units;
            tick_next  = (item.op == OP_TICK);
        end
        else if (walk)
        begin
            cnt_next              = cnt_reg + CNT_W'(1);
            mask_next             = mask_reg >> 1;
            mask_next[NUM_TIMERS-1] = head_fired;
        end
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            units_reg     <= '0;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            units_reg     <= units_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_reg.fired_mask   <= tick_reg ? fired8 : 8'd0;
            out_reg.units_ticked <= tick_reg ? units_reg : 3'd0;
            out_reg.ms_total     <= totals.ms;
            out_reg.cs_total     <= totals.cs;
            out_reg.ds_total     <= totals.ds;
            out_reg.s_total      <= totals.s;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
